[rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PCM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define PCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pcm_ssa_pkg.sv]
`timescale 1ns / 1ps

package pcm_ssa_pkg;

    localparam int RAW_W = 16;
    localparam int ACC_W = 32;
    localparam int VOL_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = RAW_W + ACC_W;
    localparam int M_TDATA_W = ACC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_IS_WIDE   = 2'd0,
        CFG_SAMPLE_IS_SIGNED = 2'd1,
        CFG_SWAP_BYTES       = 2'd2,
        CFG_SOURCE_VOLUME    = 2'd3
    } cfg_index_t;

    localparam logic             RST_SAMPLE_IS_WIDE   = 1'b1;
    localparam logic             RST_SAMPLE_IS_SIGNED = 1'b1;
    localparam logic             RST_SWAP_BYTES       = 1'b0;
    localparam logic [VOL_W-1:0] RST_SOURCE_VOLUME    = 9'd256;

endpackage

[rtl/pcm_sample_scale_accumulate.sv]
`timescale 1ns / 1ps
// pcm_sample_scale_accumulate
// adds one volume-scaled pcm source sample to a 32-bit mix accumulator value.
// input stream (s_): each beat carries the raw sample, the current accumulator
// value for that sample position and a last-of-buffer mark on s_tlast.
// result stream (m_): each beat carries the new accumulator value, wrapped at
// 32 bits, with s_tlast copied to m_tlast. one result beat per input beat.
// sample format and volume come from a plain write port (cfg_we, cfg_index,
// cfg_wdata); write it only while no beats are in flight.
// pipeline: each input beat goes into the input register, then decode, 16x9
// multiply and 32-bit add into the result register.
// throughput: one beat per cycle unless stalled (single multiply-add stage).
// when the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_tready falls only when both are full.
// reset (aresetn low, synchronous) empties both stages and restores the
// formats to 16-bit signed, no byte swap, unity volume.
module pcm_sample_scale_accumulate
    import pcm_ssa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VOL_W-1:0]     cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // raw_sample [15:0], acc_in [47:16]
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // acc_out [31:0]
    output logic                 m_tlast
);

    logic             sample_is_wide_reg;
    logic             sample_is_signed_reg;
    logic             swap_bytes_reg;
    logic [VOL_W-1:0] source_volume_reg;

    logic             in_valid_reg;
    logic [RAW_W-1:0] in_raw_reg;
    logic [ACC_W-1:0] in_acc_reg;
    logic             in_last_reg;

    logic             out_valid_reg;
    logic [ACC_W-1:0] out_acc_reg;
    logic             out_last_reg;

    logic                         out_advance;
    logic                         in_load;
    logic [RAW_W-1:0]             wide_bits;
    logic [7:0]                   narrow_bits;
    logic signed [RAW_W-1:0]      decoded;
    logic signed [RAW_W+VOL_W-1:0] product;
    logic signed [RAW_W:0]        scaled;
    logic [ACC_W-1:0]             acc_next;

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_load     = s_tvalid && s_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_is_wide_reg   <= RST_SAMPLE_IS_WIDE;
            sample_is_signed_reg <= RST_SAMPLE_IS_SIGNED;
            swap_bytes_reg       <= RST_SWAP_BYTES;
            source_volume_reg    <= RST_SOURCE_VOLUME;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_IS_WIDE:   sample_is_wide_reg   <= cfg_wdata[0];
                CFG_SAMPLE_IS_SIGNED: sample_is_signed_reg <= cfg_wdata[0];
                CFG_SWAP_BYTES:       swap_bytes_reg       <= cfg_wdata[0];
                CFG_SOURCE_VOLUME:    source_volume_reg    <= cfg_wdata;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_raw_reg  <= s_tdata[RAW_W-1:0];
            in_acc_reg  <= s_tdata[S_TDATA_W-1:RAW_W];
            in_last_reg <= s_tlast;
        end
    end

    // decode, scale and accumulate
    always_comb begin
        wide_bits   = swap_bytes_reg ? {in_raw_reg[7:0], in_raw_reg[15:8]} : in_raw_reg;
        wide_bits   = {wide_bits[15] ^ !sample_is_signed_reg, wide_bits[14:0]};
        narrow_bits = {in_raw_reg[7] ^ !sample_is_signed_reg, in_raw_reg[6:0]};
        if (sample_is_wide_reg) begin
            decoded = $signed(wide_bits);
        end else begin
            decoded = $signed({{8{narrow_bits[7]}}, narrow_bits});
        end
        product = decoded * $signed({1'b0, source_volume_reg[VOL_W-2:0]});
        // floor division by 256 keeps bits above the low byte
        if (source_volume_reg[VOL_W-1]) begin
            scaled = {decoded[RAW_W-1], decoded};
        end else begin
            scaled = product[RAW_W+VOL_W-1:8];
        end
        acc_next = in_acc_reg + {{(ACC_W-RAW_W-1){scaled[RAW_W]}}, scaled};
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            out_acc_reg  <= acc_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_acc_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/pcm_ssa_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcm_ssa_checker
    import pcm_ssa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    `PCM_ASSERT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `PCM_ASSERT(a_out_beat_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
    `PCM_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result beat present after reset")
    `PCM_ASSERT(a_ready_follows_sink, aclk, aresetn, m_tready |-> s_tready, "input stalled while result side drains")

endmodule

bind pcm_sample_scale_accumulate pcm_ssa_checker u_pcm_ssa_checker (.*);
